// File: src/dbsq_pkg.sv
`timescale 1ns / 1ps

package dbsq_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int PEND_DEF  = 128;

	// command codes
	localparam logic [2:0] K_PREALLOC = 3'd0;
	localparam logic [2:0] K_DEQUEUE  = 3'd1;
	localparam logic [2:0] K_REQUEST  = 3'd2;
	localparam logic [2:0] K_QUEUE    = 3'd3;
	localparam logic [2:0] K_CANCEL   = 3'd4;
	localparam logic [2:0] K_ACQUIRE  = 3'd5;
	localparam logic [2:0] K_RELEASE  = 3'd6;
	localparam logic [2:0] K_CONNECT  = 3'd7;

	// slot states
	localparam logic [2:0] ST_UNALLOC = 3'd0;
	localparam logic [2:0] ST_FREE    = 3'd1;
	localparam logic [2:0] ST_DEQ     = 3'd2;
	localparam logic [2:0] ST_QUEUED  = 3'd3;
	localparam logic [2:0] ST_ACQ     = 3'd4;

	// result status codes
	localparam logic [2:0] RS_OK   = 3'd0;
	localparam logic [2:0] RS_BAD  = 3'd1;
	localparam logic [2:0] RS_NONE = 3'd2;
	localparam logic [2:0] RS_DISC = 3'd3;
	localparam logic [2:0] RS_OVF  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  slot;
		logic [13:0] width;
		logic [13:0] height;
		logic [7:0]  transform;
		logic [7:0]  swap_ivl;
		logic        connect_flag;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  out_slot;
		logic [13:0] out_width;
		logic [13:0] out_height;
		logic [7:0]  out_transform;
		logic [7:0]  out_swap;
	} rsp_t;

	// one slot table entry
	typedef struct packed {
		logic [2:0]  st;
		logic [13:0] w;
		logic [13:0] h;
		logic [7:0]  xf;
		logic [7:0]  sw;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_DQ_RDF,
		S_DQ_RDS,
		S_DQ_CHK,
		S_SH_RD,
		S_SH_WR,
		S_POP_RD,
		S_POP_S,
		S_POP_CHK,
		S_RES
	} fsm_t;

endpackage

// File: src/dbsq_ram.sv
`timescale 1ns / 1ps

module dbsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/display_buffer_slot_queue.sv
`timescale 1ns / 1ps

// Display buffer slot queue.
// One command word enters on cmd (cmd_valid/cmd_ready) and gives exactly one
// result word on rsp (rsp_valid/rsp_ready). Commands are handled one at a time
// by a sequencer around three single-port-read memories: the slot table, the
// free list and the pending order ring.
// Most commands pass through S_LOOK and S_RES before rsp_valid rises, and a
// new command is accepted only when the sequencer is back in S_IDLE.
// Dequeue scans the free list entry by entry (free-list read, slot read,
// check), then compacts the list by moving each later entry down one place.
// Acquire pops order entries one by one, stale entries included.
// The next command is taken once the previous result sits in the output
// register, so with a stalled receiver one more command runs and waits in
// S_RES, holding cmd_ready low until rsp_ready frees the register.
// Reset: all slots unallocated (per-slot valid flops), free list and order
// ring empty, disconnected; no clearing pass is needed.
module display_buffer_slot_queue #(
	parameter int SLOTS         = dbsq_pkg::SLOTS_DEF,
	parameter int PENDING_DEPTH = dbsq_pkg::PEND_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  dbsq_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dbsq_pkg::rsp_t  rsp
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int QW = $clog2(PENDING_DEPTH + 1);

	dbsq_pkg::fsm_t state_q, state_d;
	dbsq_pkg::cmd_t cmd_q, cmd_d;
	dbsq_pkg::rsp_t res_q, res_d, rsp_q, rsp_d;
	logic           rsp_valid_q, rsp_valid_d;
	logic [SLOTS-1:0] vld_q, vld_d;
	logic           conn_q, conn_d;
	logic [CW-1:0]  fcnt_q, fcnt_d, i_q, i_d, ip1;
	logic [PW-1:0]  head_q, head_d, tail_q, tail_d;
	logic [QW-1:0]  pcnt_q, pcnt_d;
	logic [SW-1:0]  c_q, c_d;

	// memory ports
	logic                  s_we;
	logic [SW-1:0]         s_waddr, s_raddr;
	dbsq_pkg::ent_t        s_wdata, s_rdata;
	logic                  f_we;
	logic [SW-1:0]         f_waddr, f_raddr, f_wdata, f_rdata;
	logic                  p_we;
	logic [PW-1:0]         p_waddr, p_raddr;
	logic [SW-1:0]         p_wdata, p_rdata;

	logic          sok;
	logic [SW-1:0] sidx;
	logic [2:0]    est;
	logic          hit;

	dbsq_ram #(.WIDTH(dbsq_pkg::ENT_W), .DEPTH(SLOTS)) u_slot (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	dbsq_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	dbsq_ram #(.WIDTH(SW), .DEPTH(PENDING_DEPTH)) u_pend (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	assign cmd_ready = (state_q == dbsq_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sok  = int'(cmd_q.slot) < SLOTS;
	assign sidx = cmd_q.slot[SW-1:0];
	assign est  = vld_q[sidx] ? s_rdata.st : dbsq_pkg::ST_UNALLOC;
	assign ip1  = i_q + 1'b1;

	// match test for the scanned slot in dequeue and acquire
	always_comb begin
		hit = 1'b0;
		if (state_q == dbsq_pkg::S_DQ_CHK) begin
			hit = vld_q[c_q] && s_rdata.st == dbsq_pkg::ST_FREE &&
				s_rdata.w == cmd_q.width && s_rdata.h == cmd_q.height;
		end else if (state_q == dbsq_pkg::S_POP_CHK) begin
			hit = vld_q[c_q] && s_rdata.st == dbsq_pkg::ST_QUEUED;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbsq_pkg::S_IDLE: begin
				if (cmd_valid) state_d = dbsq_pkg::S_LOOK;
			end
			dbsq_pkg::S_LOOK: begin
				if (cmd_q.kind == dbsq_pkg::K_DEQUEUE && conn_q) begin
					state_d = dbsq_pkg::S_DQ_RDF;
				end else if (cmd_q.kind == dbsq_pkg::K_ACQUIRE) begin
					state_d = dbsq_pkg::S_POP_RD;
				end else begin
					state_d = dbsq_pkg::S_RES;
				end
			end
			dbsq_pkg::S_DQ_RDF: begin
				state_d = (i_q == fcnt_q) ? dbsq_pkg::S_RES : dbsq_pkg::S_DQ_RDS;
			end
			dbsq_pkg::S_DQ_RDS: state_d = dbsq_pkg::S_DQ_CHK;
			dbsq_pkg::S_DQ_CHK: begin
				state_d = hit ? dbsq_pkg::S_SH_RD : dbsq_pkg::S_DQ_RDF;
			end
			dbsq_pkg::S_SH_RD: begin
				state_d = (i_q >= fcnt_q) ? dbsq_pkg::S_RES : dbsq_pkg::S_SH_WR;
			end
			dbsq_pkg::S_SH_WR: state_d = dbsq_pkg::S_SH_RD;
			dbsq_pkg::S_POP_RD: begin
				state_d = (pcnt_q == '0) ? dbsq_pkg::S_RES : dbsq_pkg::S_POP_S;
			end
			dbsq_pkg::S_POP_S: state_d = dbsq_pkg::S_POP_CHK;
			dbsq_pkg::S_POP_CHK: begin
				state_d = hit ? dbsq_pkg::S_RES : dbsq_pkg::S_POP_RD;
			end
			dbsq_pkg::S_RES: begin
				if (!rsp_valid_q || rsp_ready) state_d = dbsq_pkg::S_IDLE;
			end
			default: state_d = dbsq_pkg::S_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		cmd_d       = cmd_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		vld_d       = vld_q;
		conn_d      = conn_q;
		fcnt_d      = fcnt_q;
		i_d         = i_q;
		head_d      = head_q;
		tail_d      = tail_q;
		pcnt_d      = pcnt_q;
		c_d         = c_q;
		s_we        = 1'b0;
		s_waddr     = sidx;
		s_wdata     = s_rdata;
		s_raddr     = cmd.slot[SW-1:0];
		f_we        = 1'b0;
		f_waddr     = fcnt_q[SW-1:0];
		f_wdata     = sidx;
		f_raddr     = (state_q == dbsq_pkg::S_SH_RD) ? ip1[SW-1:0] : i_q[SW-1:0];
		p_we        = 1'b0;
		p_waddr     = tail_q;
		p_wdata     = sidx;
		p_raddr     = head_q;
		case (state_q)
			dbsq_pkg::S_IDLE: begin
				if (cmd_valid) cmd_d = cmd;
			end
			dbsq_pkg::S_LOOK: begin
				res_d = '0;
				case (cmd_q.kind)
					dbsq_pkg::K_PREALLOC: begin
						if (!sok) begin
							res_d.status = dbsq_pkg::RS_BAD;
						end else begin
							if (est != dbsq_pkg::ST_FREE && fcnt_q != CW'(SLOTS)) begin
								f_we   = 1'b1;
								fcnt_d = fcnt_q + 1'b1;
							end
							s_we          = 1'b1;
							s_wdata.st    = dbsq_pkg::ST_FREE;
							s_wdata.w     = cmd_q.width;
							s_wdata.h     = cmd_q.height;
							s_wdata.xf    = '0;
							s_wdata.sw    = '0;
							vld_d[sidx]   = 1'b1;
						end
					end
					dbsq_pkg::K_DEQUEUE: begin
						res_d.status = conn_q ? dbsq_pkg::RS_NONE : dbsq_pkg::RS_DISC;
						i_d = '0;
					end
					dbsq_pkg::K_REQUEST: begin
						if (!sok || est != dbsq_pkg::ST_DEQ) begin
							res_d.status = dbsq_pkg::RS_BAD;
						end else begin
							res_d.out_slot   = cmd_q.slot;
							res_d.out_width  = s_rdata.w;
							res_d.out_height = s_rdata.h;
						end
					end
					dbsq_pkg::K_QUEUE: begin
						if (!sok || est != dbsq_pkg::ST_DEQ) begin
							res_d.status = dbsq_pkg::RS_BAD;
						end else if (pcnt_q == QW'(PENDING_DEPTH)) begin
							res_d.status = dbsq_pkg::RS_OVF;
						end else begin
							s_we       = 1'b1;
							s_wdata.st = dbsq_pkg::ST_QUEUED;
							s_wdata.xf = cmd_q.transform;
							s_wdata.sw = cmd_q.swap_ivl;
							p_we       = 1'b1;
							tail_d     = (tail_q == PW'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
							pcnt_d     = pcnt_q + 1'b1;
						end
					end
					dbsq_pkg::K_CANCEL: begin
						if (!sok || est == dbsq_pkg::ST_UNALLOC || est == dbsq_pkg::ST_FREE) begin
							res_d.status = dbsq_pkg::RS_BAD;
						end else begin
							s_we       = 1'b1;
							s_wdata.st = dbsq_pkg::ST_FREE;
							s_wdata.sw = '0;
							if (fcnt_q != CW'(SLOTS)) begin
								f_we   = 1'b1;
								fcnt_d = fcnt_q + 1'b1;
							end
						end
					end
					dbsq_pkg::K_ACQUIRE: begin
						res_d.status = dbsq_pkg::RS_NONE;
					end
					dbsq_pkg::K_RELEASE: begin
						if (!sok || est != dbsq_pkg::ST_ACQ) begin
							res_d.status = dbsq_pkg::RS_BAD;
						end else begin
							s_we       = 1'b1;
							s_wdata.st = dbsq_pkg::ST_FREE;
							if (fcnt_q != CW'(SLOTS)) begin
								f_we   = 1'b1;
								fcnt_d = fcnt_q + 1'b1;
							end
						end
					end
					default: begin
						// connect or disconnect: drop the order ring; disconnect also frees all slots
						head_d = '0;
						tail_d = '0;
						pcnt_d = '0;
						if (cmd_q.connect_flag) begin
							conn_d = 1'b1;
						end else begin
							conn_d = 1'b0;
							vld_d  = '0;
							fcnt_d = '0;
						end
					end
				endcase
			end
			dbsq_pkg::S_DQ_RDS: begin
				c_d     = f_rdata;
				s_raddr = f_rdata;
			end
			dbsq_pkg::S_DQ_CHK: begin
				if (hit) begin
					s_we           = 1'b1;
					s_waddr        = c_q;
					s_wdata.st     = dbsq_pkg::ST_DEQ;
					fcnt_d         = fcnt_q - 1'b1;
					res_d.status   = dbsq_pkg::RS_OK;
					res_d.out_slot = 6'(c_q);
				end else begin
					i_d = ip1;
				end
			end
			dbsq_pkg::S_SH_WR: begin
				// close the gap left by the taken entry
				f_we    = 1'b1;
				f_waddr = i_q[SW-1:0];
				f_wdata = f_rdata;
				i_d     = ip1;
			end
			dbsq_pkg::S_POP_RD: begin
				if (pcnt_q != '0) begin
					head_d = (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
					pcnt_d = pcnt_q - 1'b1;
				end
			end
			dbsq_pkg::S_POP_S: begin
				c_d     = p_rdata;
				s_raddr = p_rdata;
			end
			dbsq_pkg::S_POP_CHK: begin
				if (hit) begin
					s_we                = 1'b1;
					s_waddr             = c_q;
					s_wdata.st          = dbsq_pkg::ST_ACQ;
					res_d.status        = dbsq_pkg::RS_OK;
					res_d.out_slot      = 6'(c_q);
					res_d.out_width     = s_rdata.w;
					res_d.out_height    = s_rdata.h;
					res_d.out_transform = s_rdata.xf;
					res_d.out_swap      = s_rdata.sw;
				end
			end
			dbsq_pkg::S_RES: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d       = res_q;
					rsp_valid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dbsq_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			vld_q       <= '0;
			conn_q      <= 1'b0;
			fcnt_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			pcnt_q      <= '0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			vld_q       <= vld_d;
			conn_q      <= conn_d;
			fcnt_q      <= fcnt_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			pcnt_q      <= pcnt_d;
		end
	end

	// hold payload
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		res_q <= res_d;
		rsp_q <= rsp_d;
		i_q   <= i_d;
		c_q   <= c_d;
	end

endmodule
